// ===== hdl/accel_tilt_roll_pitch_macros.svh =====
// Assertion macros used by the checker file hdl/atrp_checker.sv
`ifndef ACCEL_TILT_ROLL_PITCH_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_MACROS_SVH

// Assert that a consequent follows an antecedent, checked outside reset
`define ATRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that a consequent holds in the cycle after an antecedent
`define ATRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/atrp_pkg.sv =====
package atrp_pkg;
    localparam int CordicStages = 16;
    localparam int AngleTableLen = 24;
    localparam int NStages = (CordicStages > AngleTableLen) ? AngleTableLen : CordicStages;
    // Square root: 32-bit radicand, 16-bit root, 2 result bits per stage
    localparam int SqrtBits = 16;
    localparam int SqrtPerStage = 2;
    localparam int SqrtStages = (SqrtBits + SqrtPerStage - 1) / SqrtPerStage;
    // CORDIC datapath widths (value << 8, gain ~1.65)
    localparam int VecW = 28;
    localparam int AccW = 24;
    // Input register, root stages, root register, CORDIC stages, rounding register
    localparam int PipeLat = 1 + SqrtStages + 1 + NStages + 1;

    typedef logic [31:0] t_rad;
    typedef logic [16:0] t_root;
    typedef logic signed [VecW-1:0] t_vec;
    typedef logic signed [AccW-1:0] t_acc;
    typedef logic signed [14:0] t_cdeg;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_acc z;
        logic zero;
    } t_cord;

    function automatic t_acc atan_lut(input int i);
        t_acc r;
        r = '0;
        case (i)
            0: r = 24'sd1152000;  1: r = 24'sd680065;  2: r = 24'sd359328;
            3: r = 24'sd182400;   4: r = 24'sd91554;   5: r = 24'sd45822;
            6: r = 24'sd22916;    7: r = 24'sd11459;   8: r = 24'sd5730;
            9: r = 24'sd2865;     10: r = 24'sd1432;   11: r = 24'sd716;
            12: r = 24'sd358;     13: r = 24'sd179;    14: r = 24'sd90;
            15: r = 24'sd45;      16: r = 24'sd22;     17: r = 24'sd11;
            18: r = 24'sd6;       19: r = 24'sd3;      20: r = 24'sd1;
            21: r = 24'sd1;       default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// ===== hdl/accel_tilt_roll_pitch.sv =====
// Channel | Valid / Ready          | Word
// in      | i_valid / o_ready      | i_accel_x, i_accel_y, i_accel_z
// out     | o_valid / i_ready      | o_roll_centideg, o_pitch_centideg
// One word accepted per cycle unless the output stalls; the delay is set by
// the square-root and CORDIC pipelines and their registers.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on the output freezes every stage; nothing is dropped.
module accel_tilt_roll_pitch import atrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    output logic o_valid,
    input  logic i_ready,
    output logic signed [14:0] o_roll_centideg,
    output logic signed [14:0] o_pitch_centideg
);
    logic [PipeLat-1:0] r_vld;
    logic en;
    logic signed [16:0] r_ax, r_ay;
    t_rad r_rxz, r_ryz;
    logic signed [16:0] r_opp_r [SqrtStages];
    logic signed [16:0] r_opp_p [SqrtStages];
    t_root root_xz, root_yz;
    logic signed [16:0] r_so_r, r_so_p;
    t_root r_sq_xz, r_sq_yz;

    // Advance whenever the last stage is empty or taken
    assign en = !r_vld[PipeLat-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[PipeLat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[PipeLat-2:0], i_valid};
    end

    // Sum the squared axes, negate x for pitch, delay the opposite sides, register the roots
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ay <= 17'(i_accel_y);
            r_ax <= -17'(i_accel_x);
            r_rxz <= 32'(i_accel_x * i_accel_x) + 32'(i_accel_z * i_accel_z);
            r_ryz <= 32'(i_accel_y * i_accel_y) + 32'(i_accel_z * i_accel_z);
            r_opp_r[0] <= r_ay;
            r_opp_p[0] <= r_ax;
            for (int s = 1; s < SqrtStages; s++) begin
                r_opp_r[s] <= r_opp_r[s-1];
                r_opp_p[s] <= r_opp_p[s-1];
            end
            r_so_r <= r_opp_r[SqrtStages-1];
            r_so_p <= r_opp_p[SqrtStages-1];
            r_sq_xz <= root_xz;
            r_sq_yz <= root_yz;
        end
    end

    atrp_sqrt u_sqrt_xz (.i_clk, .i_en(en), .i_rad(r_rxz), .o_root(root_xz));
    atrp_sqrt u_sqrt_yz (.i_clk, .i_en(en), .i_rad(r_ryz), .o_root(root_yz));

    atrp_cordic u_roll (.i_clk, .i_en(en), .i_opp(r_so_r), .i_adj(r_sq_xz),
                        .o_angle(o_roll_centideg));
    atrp_cordic u_pitch (.i_clk, .i_en(en), .i_opp(r_so_p), .i_adj(r_sq_yz),
                         .o_angle(o_pitch_centideg));
endmodule

// ===== hdl/atrp_sqrt.sv =====
module atrp_sqrt import atrp_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_rad i_rad,
    output t_root o_root
);
    // Per-stage remainder and partial root, restoring method
    logic [33:0] r_rem [1:SqrtStages];
    logic [16:0] r_root [1:SqrtStages];
    t_rad r_rad [1:SqrtStages-1];
    logic [33:0] w_rem [SqrtStages];
    logic [16:0] w_root [SqrtStages];
    t_rad w_rad [SqrtStages];
    logic [33:0] n_rem [SqrtStages];
    logic [16:0] n_root [SqrtStages];

    // Feed each stage: the fresh radicand first, then the registered stages
    always_comb begin
        w_rem[0] = '0;
        w_root[0] = '0;
        w_rad[0] = i_rad;
        for (int s = 1; s < SqrtStages; s++) begin
            w_rem[s] = r_rem[s];
            w_root[s] = r_root[s];
            w_rad[s] = r_rad[s];
        end
    end

    always_comb begin
        for (int s = 0; s < SqrtStages; s++) begin
            logic [33:0] rm;
            logic [16:0] rt;
            logic [33:0] trial;
            int b;
            rm = w_rem[s];
            rt = w_root[s];
            trial = '0;
            for (int k = 0; k < SqrtPerStage; k++) begin
                b = SqrtBits - 1 - (s * SqrtPerStage + k);
                if (b >= 0) begin
                    rm = {rm[31:0], w_rad[s][2*b+1 -: 2]};
                    trial = {15'd0, rt, 2'b01};
                    if (rm >= trial) begin
                        rm = rm - trial;
                        rt = {rt[15:0], 1'b1};
                    end else begin
                        rt = {rt[15:0], 1'b0};
                    end
                end
            end
            n_rem[s] = rm;
            n_root[s] = rt;
        end
    end

    // Advance the root pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SqrtStages; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_root[s+1] <= n_root[s];
            end
            for (int s = 1; s < SqrtStages; s++) begin
                r_rad[s] <= w_rad[s-1];
            end
        end
    end

    // Round to nearest: remainder above root rounds up
    assign o_root = (r_rem[SqrtStages] > {17'd0, r_root[SqrtStages]})
                    ? r_root[SqrtStages] + 17'd1 : r_root[SqrtStages];
endmodule

// ===== hdl/atrp_cordic.sv =====
module atrp_cordic import atrp_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  logic signed [16:0] i_opp,
    input  t_root i_adj,
    output t_cdeg o_angle
);
    t_cord r_st [1:NStages];
    t_cord w_st [NStages];
    t_cord n_st [NStages];
    t_cord r_out;
    t_acc  a_abs;
    logic [AccW-1:0] a_sum;
    logic [AccW-9:0] a_rnd;

    // Scale the operands into the first stage, then take the registered stages
    always_comb begin
        w_st[0].x = t_vec'({1'b0, i_adj, 8'd0});
        w_st[0].y = t_vec'({{(VecW-25){i_opp[16]}}, i_opp, 8'd0});
        w_st[0].z = '0;
        w_st[0].zero = (i_opp == '0) && (i_adj == '0);
        for (int i = 1; i < NStages; i++) w_st[i] = r_st[i];
    end

    // One micro-rotation per stage
    always_comb begin
        for (int i = 0; i < NStages; i++) begin
            n_st[i] = w_st[i];
            if (!w_st[i].y[VecW-1]) begin
                n_st[i].x = w_st[i].x + (w_st[i].y >>> i);
                n_st[i].y = w_st[i].y - (w_st[i].x >>> i);
                n_st[i].z = w_st[i].z + atan_lut(i);
            end else begin
                n_st[i].x = w_st[i].x - (w_st[i].y >>> i);
                n_st[i].y = w_st[i].y + (w_st[i].x >>> i);
                n_st[i].z = w_st[i].z - atan_lut(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 1; i <= NStages; i++) r_st[i] <= n_st[i-1];
            r_out <= r_st[NStages];
        end
    end

    // Round half away from zero, clamp to +/-90 degrees
    assign a_abs = r_out.z[AccW-1] ? -r_out.z : r_out.z;
    assign a_sum = a_abs + t_acc'(128);
    assign a_rnd = a_sum[AccW-1:8];
    always_comb begin
        logic [14:0] m;
        m = (a_rnd > 9000) ? 15'd9000 : a_rnd[14:0];
        if (r_out.zero) o_angle = '0;
        else o_angle = r_out.z[AccW-1] ? -t_cdeg'(m) : t_cdeg'(m);
    end
endmodule

// ===== hdl/atrp_checker.sv =====
`include "accel_tilt_roll_pitch_macros.svh"
module atrp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic signed [14:0] o_roll_centideg,
    input logic signed [14:0] o_pitch_centideg
);
    `ATRP_ASSERT_IMP(a_roll_rng, i_clk, i_rst_n, o_valid,
        (o_roll_centideg <= 15'sd9000) && (o_roll_centideg >= -15'sd9000))
    `ATRP_ASSERT_IMP(a_pitch_rng, i_clk, i_rst_n, o_valid,
        (o_pitch_centideg <= 15'sd9000) && (o_pitch_centideg >= -15'sd9000))
    `ATRP_ASSERT_IMP(a_rdy_free, i_clk, i_rst_n, !o_valid, o_ready)
    `ATRP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_roll_centideg))
endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready,
    .o_roll_centideg, .o_pitch_centideg
);

// ===== tb/accel_tilt_roll_pitch_checker.sv =====
`timescale 1ns / 1ps

// Watch both channels, predict the tilt angles of each input word and compare
module accel_tilt_checker import atrp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic              i_out_valid,
    input  logic              i_ready,
    input  logic signed [14:0] i_roll,
    input  logic signed [14:0] i_pitch,
    output int                o_errors,
    output int                o_pending
);

    typedef struct {
        t_cdeg roll;
        t_cdeg pitch;
    } t_angle_pair;

    t_angle_pair angle_q[$];
    int          err_cnt = 0;

    // atan(2^-i) in 1/256 centidegree
    longint atan_steps[24] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45,
        22, 11, 6, 3, 1, 1, 0, 0
    };

    assign o_errors  = err_cnt;
    assign o_pending = angle_q.size();

    // Integer square root, rounded to nearest
    function automatic longint unsigned root_nearest(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 32;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (n > res) res++;
        return res;
    endfunction

    // atan2(opp, adj) for adj >= 0, in centidegrees, by CORDIC vectoring
    function automatic t_cdeg tilt_centideg(input longint opp, input longint adj);
        longint vx, vy, ang, mag, r, dx, dy;
        if (opp == 0 && adj == 0) return '0;
        vx  = adj * 256;
        vy  = opp * 256;
        ang = 0;
        for (int i = 0; i < NStages; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx  += dx;
                vy  -= dy;
                ang += atan_steps[i];
            end else begin
                vx  -= dx;
                vy  += dy;
                ang -= atan_steps[i];
            end
        end
        mag = (ang < 0) ? -ang : ang;
        r   = (mag + 128) >>> 8;
        if (ang < 0) r = -r;
        if (r > 9000) r = 9000;
        if (r < -9000) r = -9000;
        return t_cdeg'(r);
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // The block may be one LSB off exact rounding
    function automatic bit near(input int a, input int b);
        return (a - b <= 1) && (b - a <= 1);
    endfunction

    always @(posedge i_clk) begin
        longint ax, ay, az;
        t_angle_pair p;
        if (i_rst_n) begin
            // Predict on an accepted input word
            if (i_valid && i_in_ready) begin
                ax = i_accel_x;
                ay = i_accel_y;
                az = i_accel_z;
                p.roll  = tilt_centideg(ay, root_nearest(ax * ax + az * az));
                p.pitch = tilt_centideg(-ax, root_nearest(ay * ay + az * az));
                angle_q.push_back(p);
            end
            // Compare an accepted output word with the oldest prediction
            if (i_out_valid && i_ready) begin
                if (angle_q.size() == 0) begin
                    report("unexpected word, roll", i_roll, 0);
                end else begin
                    p = angle_q.pop_front();
                    if (!near(i_roll, p.roll)) report("roll", i_roll, p.roll);
                    if (!near(i_pitch, p.pitch)) report("pitch", i_pitch, p.pitch);
                end
            end
        end
    end

endmodule

// ===== tb/accel_tilt_roll_pitch_tb.sv =====
`timescale 1ns / 1ps

module accel_tilt_roll_pitch_tb;
    import atrp_pkg::*;

    localparam int NRand     = 930;
    localparam int CycleCap  = 300000;
    localparam int Latency   = PipeLat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [14:0] o_roll_centideg;
    logic signed [14:0] o_pitch_centideg;

    int  err_cnt;
    int  pending;
    int  sent_cnt = 0;
    int  cycle_cnt = 0;
    bit  gaps_on = 1'b1;
    bit  long_hold = 1'b0;
    int  stall_left = 0;

    always #10 i_clk = ~i_clk;

    accel_tilt_roll_pitch dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_roll_centideg (o_roll_centideg),
        .o_pitch_centideg(o_pitch_centideg)
    );

    accel_tilt_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_ready (o_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_out_valid(o_valid),
        .i_ready    (i_ready),
        .i_roll     (o_roll_centideg),
        .i_pitch    (o_pitch_centideg),
        .o_errors   (err_cnt),
        .o_pending  (pending)
    );

    // Bail out on a hang
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleCap) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: random stall bursts, plus one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n || long_hold) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Hold the output long enough to back the pipeline up
    initial begin
        wait (sent_cnt >= 300);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (Latency * 4) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Offer one word and hold it until accepted
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_cnt++;
    endtask

    function automatic logic [15:0] rand_axis(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return 16'($signed($urandom_range(0, 40000)) - 20000);
            default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    initial begin
        int mode;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, axes, extremes, most negative x
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'h0000);
        send_sample(16'h7FFF, 16'h8000, 16'h8000);
        send_sample(16'h0001, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
        send_sample(16'h0001, 16'h0001, 16'h0001);
        send_sample(16'h0000, 16'h0001, 16'hFFFF);
        send_sample(16'h4000, 16'h4000, 16'h0000);
        send_sample(16'hC000, 16'h0000, 16'h4000);
        send_sample(16'h0000, 16'h0000, 16'h4000);
        send_sample(16'h8000, 16'h0000, 16'h7FFF);

        // Random: full range, tiny, gravity-scale and rail values
        for (int n = 0; n < NRand; n++) begin
            if (n > NRand - 100) gaps_on = 1'b0;
            mode = $urandom_range(0, 9);
            mode = (mode < 4) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
            send_sample(rand_axis(mode), rand_axis($urandom_range(0, 3)),
                        rand_axis(mode));
        end
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
